// File: rtl/rps_pkg.sv
`default_nettype none

package rps_pkg;

  // fixed-point format of time and factor
  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE_Q = 17'(1 << FRAC_BITS);
  localparam int HALF_Q = 1 << (FRAC_BITS - 1);

  // exp(-x) table geometry
  localparam int TABLE_POINTS = 1024;
  localparam int EXP_SPAN = 16;
  localparam int TAB_AW = $clog2(TABLE_POINTS);
  localparam int IDX_LSB = FRAC_BITS - $clog2(TABLE_POINTS / EXP_SPAN);
  localparam int ARG_W = 23;

  // logistic divider
  localparam int QUO_W = 17;
  localparam int DIV_W = 50;
  localparam int DEN_W = 34;

  typedef enum logic [3:0] {
    PRF_LINEAR    = 4'd0,
    PRF_QUAD      = 4'd1,
    PRF_SMOOTH    = 4'd2,
    PRF_SIGMOID   = 4'd3,
    PRF_EXP       = 4'd4,
    PRF_INV_CUBIC = 4'd5,
    PRF_TANH      = 4'd6,
    PRF_HERMITE   = 4'd7,
    PRF_STEP      = 4'd8
  } profile_t;

  // sideband that rides along the divider stages
  typedef struct packed {
    logic        logi;
    logic        neg;
    logic        bad;
    logic [16:0] fsel;
  } side_t;

  typedef logic [32:0] exp_tab_t [TABLE_POINTS + 1];

  // exp(-i*span/points) in q32, built with exact integer steps
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    logic [64:0] d;
    logic [64:0] term;
    logic [64:0] r;
    logic [64:0] acc;
    d = (65'(EXP_SPAN) << 32) / 65'(TABLE_POINTS);
    term = 65'd1 << 32;
    r = 65'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * d) >> 32) / 65'(k);
      if (k[0]) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    tab[0] = 33'h1_0000_0000;
    for (int i = 1; i <= TABLE_POINTS; i++) begin
      acc = 65'(tab[i - 1]) * r + (65'd1 << 31);
      tab[i] = 33'(acc >> 32);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ramp_profile_shaper.sv
`default_nettype none
// the done strobe follows an accepted transaction through stages 1 to 8, the stage 9 divider load,
// the divider stages and the done register; throughput: one transaction per cycle outside reset,
// every profile takes the same path length, most of it the 17-stage restoring divider of the logistic profiles
// reset (synchronous, rst high): profile_select back to linear, all stage valids cleared
// busy is high only during reset; the receiver cannot stall, results are never held

module ramp_profile_shaper (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [19:0] time_ratio,
  input  wire logic               cfg_write,
  input  wire logic [3:0]         cfg_data,
  output logic                    done,
  output logic [16:0]             ramp_factor,
  output logic                    bad_profile
);
  import rps_pkg::*;

  localparam int DIV_STEPS = QUO_W;
  localparam exp_tab_t EXP_ROM = build_exp_tab();

  // configuration register
  logic [3:0] profile_select;

  // stage valids
  logic v1, v2, v3, v4, v5, v6, v7, v8;

  // stage 1: captured transaction
  logic signed [19:0] t1;
  logic [3:0]         p1;

  // stage 2: clamp and center
  logic [16:0]        c2;
  logic signed [20:0] u2;
  logic               step2;
  logic [3:0]         p2;

  // stage 3: scaled logistic argument, first squares
  logic signed [23:0] z3;
  logic [33:0]        sq3;
  logic [16:0]        m3;
  logic [18:0]        a5_3;
  logic [16:0]        c3;
  logic               step3;
  logic [3:0]         p3;

  // stage 4: table argument
  logic [ARG_W-1:0]   a4;
  logic               neg4;
  logic [16:0]        q4;
  logic [33:0]        mm4;
  logic [17:0]        w4;
  logic [16:0]        m4;
  logic [16:0]        c4;
  logic               step4;
  logic [3:0]         p4;

  // stage 5: table read
  logic [32:0]        elo5;
  logic [32:0]        ehi5;
  logic [IDX_LSB-1:0] fr5;
  logic               sat5;
  logic [34:0]        sm5;
  logic [16:0]        mmq5;
  logic [16:0]        m5;
  logic               neg5;
  logic [16:0]        q5;
  logic [16:0]        c5;
  logic               step5;
  logic [3:0]         p5;

  // stage 6
  logic [32:0]        dif6;
  logic [32:0]        elo6;
  logic [IDX_LSB-1:0] fr6;
  logic               sat6;
  logic [16:0]        smooth6;
  logic [33:0]        cube6;
  logic               neg6;
  logic [16:0]        q6;
  logic [16:0]        c6;
  logic               step6;
  logic [3:0]         p6;

  // stage 7: interpolation product
  logic [42:0]        prod7;
  logic [32:0]        elo7;
  logic               sat7;
  logic [16:0]        smooth7;
  logic [16:0]        cubic7;
  logic               neg7;
  logic [16:0]        q7;
  logic [16:0]        c7;
  logic               step7;
  logic [3:0]         p7;

  // stage 8: interpolated exp(-x), per-profile pick
  logic [32:0]        e8;
  side_t              side8;
  logic [3:0]         p8;

  // divider pipeline, entry 0 is the stage 9 load
  logic [DIV_W-1:0]   d_rem  [DIV_STEPS + 1];
  logic [DEN_W-1:0]   d_den  [DIV_STEPS + 1];
  logic [QUO_W-1:0]   d_quo  [DIV_STEPS + 1];
  side_t              d_side [DIV_STEPS + 1];
  logic               d_vld  [DIV_STEPS + 1];

  // combinational helpers
  logic signed [23:0] u_ext;
  logic signed [23:0] z_next;
  logic [23:0]        z_mag;
  logic [TAB_AW:0]    addr_lo;
  logic [TAB_AW:0]    addr_hi;
  logic               sat_next;
  logic [18:0]        smooth_rnd;
  logic [16:0]        fsel_next;
  logic [17:0]        exp_rnd;
  logic [16:0]        fsel9;
  logic [QUO_W-1:0]   quo_cap;
  logic [16:0]        logi_f;

  assign busy = rst;

  // config write, only while idle: the user must keep to this, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      profile_select <= 4'(PRF_LINEAR);
    end else if (cfg_write) begin
      profile_select <= cfg_data;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      d_vld[0] <= 1'b0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      d_vld[0] <= v8;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    t1 <= time_ratio;
    p1 <= profile_select;
  end

  // stage 2: clamp t to 0..one, center for the logistic profiles
  always_ff @(posedge clk) begin
    if (t1 < 20'sd0) begin
      c2 <= '0;
    end else if (t1 > 20'sd65536) begin
      c2 <= ONE_Q;
    end else begin
      c2 <= t1[16:0];
    end
    u2    <= {t1[19], t1} - 21'sd32768;
    step2 <= (t1 >= 20'sd65536);
    p2    <= p1;
  end

  // stage 3: z = 12u for tanh, 10u for sigmoid
  assign u_ext  = 24'(u2);
  assign z_next = (p2 == 4'(PRF_TANH)) ? (u_ext <<< 3) + (u_ext <<< 2)
                                       : (u_ext <<< 3) + (u_ext <<< 1);

  always_ff @(posedge clk) begin
    z3    <= z_next;
    sq3   <= 34'(c2) * 34'(c2);
    m3    <= ONE_Q - c2;
    a5_3  <= (19'(c2) << 2) + 19'(c2);
    c3    <= c2;
    step3 <= step2;
    p3    <= p2;
  end

  // stage 4: table argument is 5c for exponential, |z| otherwise
  assign z_mag = z3[23] ? 24'(-z3) : 24'(z3);

  always_ff @(posedge clk) begin
    if (p3 == 4'(PRF_EXP)) begin
      a4 <= ARG_W'(a5_3);
    end else begin
      a4 <= z_mag[ARG_W-1:0];
    end
    neg4  <= z3[23];
    q4    <= 17'((sq3 + 34'(HALF_Q)) >> FRAC_BITS);
    mm4   <= 34'(m3) * 34'(m3);
    w4    <= 18'(3 * ONE_Q) - (18'(c3) << 1);
    m4    <= m3;
    c4    <= c3;
    step4 <= step3;
    p4    <= p3;
  end

  // stage 5: two-port table read, past the window the exp reads as zero
  assign sat_next = |a4[ARG_W-1:IDX_LSB+TAB_AW];
  assign addr_lo  = sat_next ? '0 : {1'b0, a4[IDX_LSB +: TAB_AW]};
  assign addr_hi  = addr_lo + 1'b1;

  always_ff @(posedge clk) begin
    elo5  <= EXP_ROM[addr_lo];
    ehi5  <= EXP_ROM[addr_hi];
    fr5   <= a4[IDX_LSB-1:0];
    sat5  <= sat_next;
    sm5   <= 35'(q4) * 35'(w4);
    mmq5  <= 17'((mm4 + 34'(HALF_Q)) >> FRAC_BITS);
    m5    <= m4;
    neg5  <= neg4;
    q5    <= q4;
    c5    <= c4;
    step5 <= step4;
    p5    <= p4;
  end

  // stage 6
  assign smooth_rnd = 19'((sm5 + 35'(HALF_Q)) >> FRAC_BITS);

  always_ff @(posedge clk) begin
    dif6    <= elo5 - ehi5;
    elo6    <= elo5;
    fr6     <= fr5;
    sat6    <= sat5;
    smooth6 <= (smooth_rnd > 19'(ONE_Q)) ? ONE_Q : smooth_rnd[16:0];
    cube6   <= 34'(mmq5) * 34'(m5);
    neg6    <= neg5;
    q6      <= q5;
    c6      <= c5;
    step6   <= step5;
    p6      <= p5;
  end

  // stage 7: slope times fraction
  always_ff @(posedge clk) begin
    prod7   <= 43'(dif6) * 43'(fr6);
    elo7    <= elo6;
    sat7    <= sat6;
    smooth7 <= smooth6;
    cubic7  <= ONE_Q - 17'((cube6 + 34'(HALF_Q)) >> FRAC_BITS);
    neg7    <= neg6;
    q7      <= q6;
    c7      <= c6;
    step7   <= step6;
    p7      <= p6;
  end

  // stage 8: finish exp(-x), pick the polynomial profiles
  always_comb begin
    fsel_next = '0;
    case (p7)
      4'(PRF_LINEAR):    fsel_next = c7;
      4'(PRF_QUAD):      fsel_next = q7;
      4'(PRF_SMOOTH):    fsel_next = smooth7;
      4'(PRF_HERMITE):   fsel_next = smooth7;
      4'(PRF_INV_CUBIC): fsel_next = cubic7;
      4'(PRF_STEP):      fsel_next = step7 ? ONE_Q : '0;
      default:           fsel_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    e8         <= sat7 ? '0 : elo7 - prod7[42:IDX_LSB];
    side8.fsel <= fsel_next;
    side8.bad  <= (p7 > 4'(PRF_STEP));
    side8.logi <= (p7 == 4'(PRF_SIGMOID)) || (p7 == 4'(PRF_TANH));
    side8.neg  <= neg7;
    p8         <= p7;
  end

  // stage 9: exponential result, divider load for 1 / (1 + exp(-|z|))
  assign exp_rnd = 18'((e8 + 33'(HALF_Q)) >> FRAC_BITS);
  assign fsel9   = (p8 == 4'(PRF_EXP)) ? ONE_Q - exp_rnd[16:0] : side8.fsel;

  always_ff @(posedge clk) begin
    d_rem[0]       <= (DIV_W'(1) << 48) + (DIV_W'(1) << 31) + DIV_W'(e8 >> 1);
    d_den[0]       <= (DEN_W'(1) << 32) + DEN_W'(e8);
    d_quo[0]       <= '0;
    d_side[0].fsel <= fsel9;
    d_side[0].bad  <= side8.bad;
    d_side[0].logi <= side8.logi;
    d_side[0].neg  <= side8.neg;
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - j;
    logic [DIV_W-1:0] den_sh;
    logic             ge;

    assign den_sh = DIV_W'(d_den[j-1]) << K;
    assign ge     = (d_rem[j-1] >= den_sh);

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[j] <= 1'b0;
      end else begin
        d_vld[j] <= d_vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      d_rem[j]  <= ge ? d_rem[j-1] - den_sh : d_rem[j-1];
      d_den[j]  <= d_den[j-1];
      d_quo[j]  <= d_quo[j-1] | (QUO_W'(ge) << K);
      d_side[j] <= d_side[j-1];
    end
  end

  // output stage: logistic mirrored for negative z
  assign quo_cap = (d_quo[DIV_STEPS] > ONE_Q) ? ONE_Q : d_quo[DIV_STEPS];
  assign logi_f  = d_side[DIV_STEPS].neg ? ONE_Q - quo_cap : quo_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    ramp_factor <= d_side[DIV_STEPS].logi ? logi_f : d_side[DIV_STEPS].fsel;
    bad_profile <= d_side[DIV_STEPS].bad;
  end

endmodule

`default_nettype wire
